FILE: rtl/schroeder_reverb_macros.svh
`ifndef SCHROEDER_REVERB_MACROS_SVH
`define SCHROEDER_REVERB_MACROS_SVH

// checked only out of reset
`define SRV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked during reset too
`define SRV_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/srv_pkg.sv
package srv_pkg;

    localparam int CombDepthDef    = 4096;
    localparam int AllpassDepthDef = 1024;

    localparam int SampleW   = 24;
    localparam int StoreW    = 28;
    localparam int GainW     = 16;
    localparam int CombLenW  = 13;
    localparam int ApLenW    = 11;
    localparam int CfgDataW  = 13;
    localparam int CfgIdxW   = 3;

    localparam logic [CfgIdxW-1:0] CfgCombA = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgCombB = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgCombC = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgCombD = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgApA   = 3'd4;
    localparam logic [CfgIdxW-1:0] CfgApB   = 3'd5;
    localparam logic [CfgIdxW-1:0] CfgApC   = 3'd6;

    localparam logic [CombLenW-1:0] CombLenReset = 13'd4096;
    localparam logic [ApLenW-1:0]   ApLenReset   = 11'd1024;

    localparam logic [GainW-1:0] ApGain = 16'd22938;

    function automatic logic [GainW-1:0] comb_gain(input logic [1:0] k);
        logic [GainW-1:0] g;
        case (k)
            2'd0:    g = 16'd26378;
            2'd1:    g = 16'd27099;
            2'd2:    g = 16'd25657;
            default: g = 16'd25035;
        endcase
        return g;
    endfunction

    typedef struct packed {
        logic       load_x;
        logic       comb_rd;
        logic       comb_mul;
        logic       comb_wr;
        logic       avg;
        logic       ap_rd;
        logic       ap_sub;
        logic       ap_mul;
        logic       ap_wr;
        logic       out_load;
        logic [1:0] k;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_done;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: rtl/srv_if.sv
interface srv_in_if;
    import srv_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [SampleW-1:0] sample_in;
    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface srv_out_if;
    import srv_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [SampleW-1:0] sample_out;
    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

FILE: rtl/srv_datapath.sv
module srv_datapath import srv_pkg::*; #(
    parameter int COMB_DEPTH    = CombDepthDef,
    parameter int ALLPASS_DEPTH = AllpassDepthDef
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    output t_dp_stat                  o_stat,
    input  logic                      i_cfg_we,
    input  logic [CfgIdxW-1:0]        i_cfg_index,
    input  logic [CfgDataW-1:0]       i_cfg_data,
    input  logic signed [SampleW-1:0] i_sample_in,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [SampleW-1:0] o_sample_out
);

    localparam int CW   = $clog2(COMB_DEPTH);
    localparam int AW   = $clog2(ALLPASS_DEPTH);
    localparam int CLRW = ((CW > AW) ? CW : AW) + 2;
    localparam int CLW  = (CombLenW > CW + 1) ? CombLenW : CW + 1;
    localparam int ALW  = (ApLenW > AW + 1) ? ApLenW : AW + 1;
    localparam logic [CLW-1:0] CombMax = CLW'(COMB_DEPTH);
    localparam logic [ALW-1:0] ApMax   = ALW'(ALLPASS_DEPTH);

    function automatic logic signed [StoreW-1:0] sat28(input logic signed [StoreW+1:0] v);
        logic signed [StoreW-1:0] s;
        if (v[StoreW+1:StoreW-1] == 3'b000 || v[StoreW+1:StoreW-1] == 3'b111) begin
            s = v[StoreW-1:0];
        end else if (v[StoreW+1]) begin
            s = {1'b1, {(StoreW-1){1'b0}}};
        end else begin
            s = {1'b0, {(StoreW-1){1'b1}}};
        end
        return s;
    endfunction

    // length registers
    logic [CombLenW-1:0] r_comb_len [4];
    logic [ApLenW-1:0]   r_ap_len   [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) r_comb_len[i] <= CombLenReset;
            for (int i = 0; i < 3; i++) r_ap_len[i] <= ApLenReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CfgCombA: r_comb_len[0] <= i_cfg_data[CombLenW-1:0];
                CfgCombB: r_comb_len[1] <= i_cfg_data[CombLenW-1:0];
                CfgCombC: r_comb_len[2] <= i_cfg_data[CombLenW-1:0];
                CfgCombD: r_comb_len[3] <= i_cfg_data[CombLenW-1:0];
                CfgApA:   r_ap_len[0]   <= i_cfg_data[ApLenW-1:0];
                CfgApB:   r_ap_len[1]   <= i_cfg_data[ApLenW-1:0];
                CfgApC:   r_ap_len[2]   <= i_cfg_data[ApLenW-1:0];
                default: ;
            endcase
        end
    end

    // pointers and effective lengths
    logic [CW-1:0] r_cptr [4];
    logic [AW-1:0] r_aptr [3];
    logic [CLW-1:0] comb_len, comb_eff, comb_nxt;
    logic [ALW-1:0] ap_len, ap_eff, ap_nxt;
    logic [CW-1:0]  comb_use, n_cptr;
    logic [AW-1:0]  ap_use, n_aptr;

    always_comb begin
        comb_len = CLW'(r_comb_len[i_cmd.k]);
        if (comb_len == '0)          comb_eff = CLW'(1);
        else if (comb_len > CombMax) comb_eff = CombMax;
        else                         comb_eff = comb_len;
        comb_use = (CLW'(r_cptr[i_cmd.k]) >= comb_eff) ? '0 : r_cptr[i_cmd.k];
        comb_nxt = CLW'(comb_use) + CLW'(1);
        n_cptr   = (comb_nxt >= comb_eff) ? '0 : comb_nxt[CW-1:0];

        ap_len = ALW'(r_ap_len[i_cmd.k]);
        if (ap_len == '0)        ap_eff = ALW'(1);
        else if (ap_len > ApMax) ap_eff = ApMax;
        else                     ap_eff = ap_len;
        ap_use = (ALW'(r_aptr[i_cmd.k]) >= ap_eff) ? '0 : r_aptr[i_cmd.k];
        ap_nxt = ALW'(ap_use) + ALW'(1);
        n_aptr = (ap_nxt >= ap_eff) ? '0 : ap_nxt[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) r_cptr[i] <= '0;
            for (int i = 0; i < 3; i++) r_aptr[i] <= '0;
        end else begin
            if (i_cmd.comb_wr) r_cptr[i_cmd.k] <= n_cptr;
            if (i_cmd.ap_wr)   r_aptr[i_cmd.k] <= n_aptr;
        end
    end

    // clearing sweep after reset
    logic [CLRW-1:0] r_clr;
    logic            r_clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= '0;
            r_clearing <= 1'b1;
        end else if (r_clearing) begin
            r_clr <= r_clr + CLRW'(1);
            if (&r_clr) r_clearing <= 1'b0;
        end
    end

    // arithmetic
    logic signed [SampleW-1:0]  r_x;
    logic signed [StoreW+1:0]   r_acc;
    logic signed [StoreW-1:0]   r_a, r_apr;
    logic signed [StoreW-1:0]   r_comb_rdata, r_ap_rdata;
    logic signed [StoreW+15:0]  r_prod;
    logic signed [StoreW-1:0]   mul_a;
    logic signed [GainW-1:0]    mul_g;
    logic signed [StoreW+15:0]  n_prod, rsum;
    logic signed [StoreW:0]     rnd;
    logic signed [StoreW-1:0]   comb_wdata, ap_wdata, ap_r;

    always_comb begin
        if (i_cmd.comb_mul)   mul_a = r_comb_rdata;
        else if (i_cmd.ap_rd) mul_a = r_a;
        else                  mul_a = r_apr;
        mul_g  = $signed(i_cmd.comb_mul ? comb_gain(i_cmd.k) : ApGain);
        n_prod = mul_a * mul_g;
        rsum   = r_prod + (StoreW+16)'(16384);
        rnd    = rsum[StoreW+15:15];
        comb_wdata = sat28({rnd[StoreW], rnd} + (StoreW+2)'(r_x));
        ap_wdata   = sat28({rnd[StoreW], rnd} + (StoreW+2)'(r_a));
        ap_r       = sat28((StoreW+2)'(r_ap_rdata) - {rnd[StoreW], rnd});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_x) r_x <= i_sample_in;
        if (i_cmd.comb_mul || i_cmd.ap_rd || i_cmd.ap_mul) r_prod <= n_prod;
        if (i_cmd.load_x)        r_acc <= '0;
        else if (i_cmd.comb_mul) r_acc <= r_acc + (StoreW+2)'(r_comb_rdata);
        if (i_cmd.avg)        r_a <= r_acc[StoreW+1:2];
        else if (i_cmd.ap_wr) r_a <= r_apr;
        if (i_cmd.ap_sub) r_apr <= ap_r;
    end

    // delay stores: four comb banks and four allpass banks (last one unused)
    logic [StoreW-1:0] r_comb_mem [4 << CW];
    logic [StoreW-1:0] r_ap_mem   [4 << AW];

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_comb_mem[r_clr[CW+1:0]] <= '0;
        end else if (i_cmd.comb_wr) begin
            r_comb_mem[{i_cmd.k, comb_use}] <= comb_wdata;
        end
        if (i_cmd.comb_rd) r_comb_rdata <= r_comb_mem[{i_cmd.k, comb_use}];
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_ap_mem[r_clr[AW+1:0]] <= '0;
        end else if (i_cmd.ap_wr) begin
            r_ap_mem[{i_cmd.k, ap_use}] <= ap_wdata;
        end
        if (i_cmd.ap_rd) r_ap_rdata <= r_ap_mem[{i_cmd.k, ap_use}];
    end

    // output register
    logic signed [SampleW-1:0] sat_out;

    always_comb begin
        if (r_a[StoreW-1:SampleW-1] == '0 || r_a[StoreW-1:SampleW-1] == '1) begin
            sat_out = r_a[SampleW-1:0];
        end else if (r_a[StoreW-1]) begin
            sat_out = {1'b1, {(SampleW-1){1'b0}}};
        end else begin
            sat_out = {1'b0, {(SampleW-1){1'b1}}};
        end
    end

    logic r_out_valid;
    logic signed [SampleW-1:0] r_sample_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) r_sample_out <= sat_out;
    end

    assign o_out_valid         = r_out_valid;
    assign o_sample_out        = r_sample_out;
    assign o_stat.clear_done   = !r_clearing;
    assign o_stat.out_free     = !r_out_valid || i_out_ready;

endmodule

FILE: rtl/srv_ctrl.sv
module srv_ctrl import srv_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

`include "schroeder_reverb_macros.svh"

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CRD, S_CMUL, S_CWR, S_AVG,
        S_ARD, S_ASUB, S_AMUL, S_AWR, S_OUT
    } t_state;

    t_state     r_state;
    logic [1:0] r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_k     <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: if (i_stat.clear_done) r_state <= S_IDLE;
                S_IDLE: begin
                    r_k <= '0;
                    if (i_in_valid) r_state <= S_CRD;
                end
                S_CRD:  r_state <= S_CMUL;
                S_CMUL: r_state <= S_CWR;
                S_CWR: begin
                    if (r_k == 2'd3) begin
                        r_k     <= '0;
                        r_state <= S_AVG;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_CRD;
                    end
                end
                S_AVG:  r_state <= S_ARD;
                S_ARD:  r_state <= S_ASUB;
                S_ASUB: r_state <= S_AMUL;
                S_AMUL: r_state <= S_AWR;
                S_AWR: begin
                    if (r_k == 2'd2) begin
                        r_state <= S_OUT;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_ARD;
                    end
                end
                S_OUT: if (i_stat.out_free) r_state <= S_IDLE;
                default: r_state <= S_CLEAR;
            endcase
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd          = '0;
        o_cmd.k        = r_k;
        o_cmd.load_x   = i_in_valid && o_in_ready;
        o_cmd.comb_rd  = (r_state == S_CRD);
        o_cmd.comb_mul = (r_state == S_CMUL);
        o_cmd.comb_wr  = (r_state == S_CWR);
        o_cmd.avg      = (r_state == S_AVG);
        o_cmd.ap_rd    = (r_state == S_ARD);
        o_cmd.ap_sub   = (r_state == S_ASUB);
        o_cmd.ap_mul   = (r_state == S_AMUL);
        o_cmd.ap_wr    = (r_state == S_AWR);
        o_cmd.out_load = (r_state == S_OUT) && i_stat.out_free;
    end

    `SRV_ASSERT(a_accept_starts_comb, (i_in_valid && o_in_ready) |=> (r_state == S_CRD && r_k == 2'd0), "accepted beat did not start the first comb")
    `SRV_ASSERT(a_out_waits, (r_state == S_OUT && !i_stat.out_free) |=> (r_state == S_OUT), "result left before output register was free")
    `SRV_ASSERT_ALWAYS(a_no_accept_in_clear, (!i_stat.clear_done) |-> !o_in_ready, "beat accepted while stores are being cleared")
    `SRV_ASSERT(a_allpass_index, (r_state == S_AWR) |-> (r_k != 2'd3), "allpass stage index out of range")

endmodule

FILE: rtl/schroeder_reverb.sv
// an accepted input beat steps through the four comb filters, their average, the three
// allpass filters and the output load before the next beat is taken, as the single shared
// multiplier and single-port comb and allpass stores serve seven filters in turn
// reset: synchronous active low; afterwards the stores are cleared, one entry of each store
// per cycle, before the first input beat is taken; configuration writes are taken throughout
module schroeder_reverb import srv_pkg::*; #(
    parameter int COMB_DEPTH    = CombDepthDef,
    parameter int ALLPASS_DEPTH = AllpassDepthDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    srv_in_if.sink              i_in,
    srv_out_if.source           o_out,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    srv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    srv_datapath #(
        .COMB_DEPTH    (COMB_DEPTH),
        .ALLPASS_DEPTH (ALLPASS_DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_sample_in  (i_in.sample_in),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_sample_out (o_out.sample_out)
    );

endmodule

FILE: sim/tb_schroeder_reverb.sv
module tb_schroeder_reverb;
    import srv_pkg::*;

    localparam int     LimitCycles = 2000000;
    localparam int     SettleGap   = 60;
    localparam longint CombGain[4] = '{26378, 27099, 25657, 25035};
    localparam longint ApGainQ     = 22938;
    localparam longint Max28 = 134217727;
    localparam longint Min28 = -134217728;
    localparam longint Max24 = 8388607;
    localparam longint Min24 = -8388608;

    typedef enum logic { ROW_SAMPLE, ROW_CFG } t_row_kind;

    typedef struct {
        t_row_kind          kind;
        logic [CfgIdxW-1:0] idx;
        int                 val;
        bit                 has_exp;
        int                 exp;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_index = '0;
    logic [CfgDataW-1:0] i_cfg_data = '0;

    srv_in_if  in_ch ();
    srv_out_if out_ch ();

    schroeder_reverb u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch.sink),
        .o_out       (out_ch.source),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // model of the filter bank
    longint comb_mem [4][CombDepthDef];
    longint ap_mem [3][AllpassDepthDef];
    int     comb_pos [4];
    int     ap_pos [3];
    logic [CombLenW-1:0] comb_len [4];
    logic [ApLenW-1:0]   ap_len [3];

    logic signed [SampleW-1:0] expected_samples [$];
    int  errors = 0;
    int  cycles = 0;
    int  idle_mode = 0;
    int  beats_out = 0;
    int  hold_left = 0;
    bit  offering = 0;

    function automatic longint scale(longint x, longint g);
        return (x * g + 64'sd16384) >>> 15;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic int eff_len(int r, int depth);
        if (r == 0) return 1;
        return r > depth ? depth : r;
    endfunction

    function automatic logic signed [SampleW-1:0] reverb_next(longint x);
        longint sum, a, r;
        int     l, p;
        sum = 0;
        for (int k = 0; k < 4; k++) begin
            l = eff_len(comb_len[k], CombDepthDef);
            p = comb_pos[k] >= l ? 0 : comb_pos[k];
            r = comb_mem[k][p];
            comb_mem[k][p] = clip(scale(r, CombGain[k]) + x, Min28, Max28);
            comb_pos[k] = p + 1 >= l ? 0 : p + 1;
            sum += r;
        end
        a = sum >>> 2;
        for (int k = 0; k < 3; k++) begin
            l = eff_len(ap_len[k], AllpassDepthDef);
            p = ap_pos[k] >= l ? 0 : ap_pos[k];
            r = clip(ap_mem[k][p] - scale(a, ApGainQ), Min28, Max28);
            ap_mem[k][p] = clip(scale(r, ApGainQ) + a, Min28, Max28);
            ap_pos[k] = p + 1 >= l ? 0 : p + 1;
            a = r;
        end
        return SampleW'(clip(a, Min24, Max24));
    endfunction

    function automatic int idle_pct(bit sender);
        if (idle_mode == 0) return sender ? 11 : 52;
        if (idle_mode == 1) return sender ? 52 : 11;
        return 0;
    endfunction

    task automatic send_sample(logic signed [SampleW-1:0] x, output logic signed [SampleW-1:0] pred);
        int gap;
        in_ch.valid <= 1'b1;
        in_ch.sample_in <= x;
        offering = 1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pred = reverb_next(longint'(x));
        expected_samples.push_back(pred);
        gap = ($urandom_range(99) < idle_pct(1)) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            offering = 0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        if (offering) begin
            in_ch.valid <= 1'b0;
            offering = 0;
        end
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (SettleGap) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, int data);
        logic [CfgDataW-1:0] d;
        d = CfgDataW'(data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx <= CfgCombD) comb_len[idx] = d[CombLenW-1:0];
        else if (idx <= CfgApC) ap_len[idx - CfgApA] = d[ApLenW-1:0];
        @(posedge i_clk);
    endtask

    function automatic logic signed [SampleW-1:0] rand_sample();
        int sel;
        sel = $urandom_range(15);
        if (sel == 0) return 24'sh7FFFFF;
        if (sel == 1) return 24'sh800000;
        if (sel < 5) return SampleW'($signed($urandom_range(0, 2000)) - 1000);
        return SampleW'($urandom);
    endfunction

    // result side: check every beat, stall at random, one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                beats_out++;
                if (expected_samples.size() == 0) begin
                    $display("%0t: unexpected beat, actual %0d", $time, out_ch.sample_out);
                    errors++;
                end else begin
                    if (out_ch.sample_out !== expected_samples[0]) begin
                        $display("%0t: sample_out expected %0d actual %0d", $time,
                                 expected_samples[0], out_ch.sample_out);
                        errors++;
                    end
                    void'(expected_samples.pop_front());
                end
                if (beats_out == 500) hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= idle_pct(0));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LimitCycles) begin
            $display("schroeder_reverb: mismatch");
            $finish;
        end
    end

    t_row rows [] = '{
        '{ROW_SAMPLE, 3'd0, 8388607, 1, 0},
        '{ROW_SAMPLE, 3'd0, -8388608, 1, 0},
        '{ROW_SAMPLE, 3'd0, 0, 1, 0},
        '{ROW_SAMPLE, 3'd0, -1, 1, 0},
        '{ROW_SAMPLE, 3'd0, 1, 1, 0},
        // zero length behaves as one, oversize clamps, stray bits dropped
        '{ROW_CFG, CfgCombA, 0, 0, 0},
        '{ROW_CFG, CfgCombB, 1, 0, 0},
        '{ROW_CFG, CfgApA, 0, 0, 0},
        '{ROW_CFG, CfgApB, 8191, 0, 0},
        '{ROW_CFG, CfgApC, 13'h1803, 0, 0},
        '{ROW_CFG, 3'd7, 5, 0, 0},
        '{ROW_SAMPLE, 3'd0, 8388607, 0, 0},
        '{ROW_SAMPLE, 3'd0, 8388607, 0, 0},
        '{ROW_SAMPLE, 3'd0, 8388607, 0, 0},
        '{ROW_SAMPLE, 3'd0, -8388608, 0, 0},
        '{ROW_SAMPLE, 3'd0, -8388608, 0, 0},
        '{ROW_SAMPLE, 3'd0, -8388608, 0, 0},
        // pointer now past the new length, must wrap
        '{ROW_CFG, CfgCombC, 3, 0, 0},
        '{ROW_CFG, CfgCombD, 8191, 0, 0},
        '{ROW_SAMPLE, 3'd0, 123456, 0, 0},
        '{ROW_SAMPLE, 3'd0, -654321, 0, 0},
        '{ROW_SAMPLE, 3'd0, 8388607, 0, 0},
        '{ROW_SAMPLE, 3'd0, -1, 0, 0}
    };

    initial begin
        logic signed [SampleW-1:0] pred;
        int lens [7];
        in_ch.valid = 1'b0;
        in_ch.sample_in = '0;
        for (int k = 0; k < 4; k++) begin
            comb_pos[k] = 0;
            comb_len[k] = CombLenReset;
            for (int i = 0; i < CombDepthDef; i++) comb_mem[k][i] = 0;
        end
        for (int k = 0; k < 3; k++) begin
            ap_pos[k] = 0;
            ap_len[k] = ApLenReset;
            for (int i = 0; i < AllpassDepthDef; i++) ap_mem[k][i] = 0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                wait_drained();
                write_reg(rows[i].idx, rows[i].val);
            end else begin
                send_sample(SampleW'(rows[i].val), pred);
                if (rows[i].has_exp && pred !== SampleW'(rows[i].exp)) begin
                    $display("%0t: row %0d expected %0d actual %0d", $time, i,
                             rows[i].exp, pred);
                    errors++;
                end
            end
        end

        for (int ph = 0; ph < 6; ph++) begin
            wait_drained();
            idle_mode = ph / 2;
            for (int r = 0; r < 7; r++) begin
                if (ph == 2) lens[r] = r < 4 ? 4096 : 1024;
                else if (ph == 3) lens[r] = 1;
                else lens[r] = $urandom_range(1, 48);
            end
            for (int r = 0; r < 7; r++) write_reg(CfgIdxW'(r), lens[r]);
            for (int n = 0; n < 240; n++) send_sample(rand_sample(), pred);
        end

        wait_drained();
        if (errors == 0) $display("schroeder_reverb: match");
        else $display("schroeder_reverb: mismatch");
        $finish;
    end

endmodule
